// File: design/hsv_to_rgb_converter_assert.svh
// Assertion macros used by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSV2RGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HSV2RGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hsv2rgb_pkg.sv
// Package with widths, constants and types of the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

  // Fixed-point format: FRAC_BITS fraction bits, one integer bit.
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned CHAN_W    = FRAC_BITS + 1;
  localparam int unsigned PROD_W    = 2 * CHAN_W;
  localparam logic [CHAN_W-1:0] ONE = CHAN_W'(1) << FRAC_BITS;

  // Hue in 1/64 degree: full circle and one 60-degree sector.
  localparam int unsigned HUE_W      = 16;
  localparam int unsigned HUE_FULL   = 23040;
  localparam int unsigned HUE_SECTOR = 3840;
  localparam int unsigned REM_W      = 12;

  // f = rem * 2^12 / 3840 = rem + rem / 15; rem / 15 = (rem * 4370) >> 16
  // is exact for every rem below 3840.
  localparam int unsigned RECIP_K     = 4370;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_PW    = REM_W + RECIP_W;

  // Stream packing.
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  // Hue sector, 60 degrees each.
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

endpackage

`default_nettype wire

// File: design/hsv_to_rgb_converter.sv
// HSV to RGB converter: HSV pixels in, RGB pixels out, four register stages.
//
// Usage:
//   Input stream (in_*): one HSV pixel per beat. Hue in 1/64 degree, any hue
//   of 360 degrees or more counts as 0. Saturation and brightness are
//   unsigned fixed point with 12 fraction bits; values above 1.0 clip to 1.0.
//   Output stream (out_*): one RGB pixel per input beat, same format, in order.
//   Each pixel passes the stage 1, stage 2, stage 3 and output registers
//   in order. Throughput: one pixel per cycle while out_tready is high. The
//   pipeline has four stages (sector decode, fraction and p product, s*f
//   products, q/t products and channel select); each holds a valid bit that
//   moves with its data.
//   Stall: when out_tready is low, stages fill up behind the output register;
//   in_tready drops only once every stage holds a pixel. No pixel is lost
//   or repeated.
//   Reset: synchronous active-low rst_n clears all valid bits; the data
//   registers are not reset, and the block accepts a pixel in the first cycle after reset.
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  // [15:0] hue, [28:16] saturation, [41:29] brightness, [47:42] zero
  input  wire logic [hsv2rgb_pkg::IN_DATA_W-1:0]   in_tdata,
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  // [12:0] red, [25:13] green, [38:26] blue, [39] zero
  output      logic [hsv2rgb_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int unsigned CW  = hsv2rgb_pkg::CHAN_W;
  localparam int unsigned FB  = hsv2rgb_pkg::FRAC_BITS;
  localparam int unsigned PW  = hsv2rgb_pkg::PROD_W;
  localparam int unsigned HW  = hsv2rgb_pkg::HUE_W;
  localparam int unsigned RW  = hsv2rgb_pkg::REM_W;
  localparam int unsigned SEC = hsv2rgb_pkg::HUE_SECTOR;
  localparam logic [CW-1:0] ONE = hsv2rgb_pkg::ONE;

  // Unpacked input fields.
  logic [HW-1:0] in_hue;
  logic [CW-1:0] in_sat;
  logic [CW-1:0] in_val;

  assign in_hue = in_tdata[HW-1:0];
  assign in_sat = in_tdata[HW+CW-1:HW];
  assign in_val = in_tdata[HW+2*CW-1:HW+CW];

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  assign s4_rdy    = !out_vld_r || out_tready;
  assign s3_rdy    = !s3_vld_r || s4_rdy;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r  <= in_tvalid;
      if (s2_rdy) s2_vld_r  <= s1_vld_r;
      if (s3_rdy) s3_vld_r  <= s2_vld_r;
      if (s4_rdy) out_vld_r <= s3_vld_r;
    end
  end

  // ---------------- Stage 1: hue wrap, sector, remainder, clipping
  logic [HW-1:0]        hue_c;
  logic [HW-1:0]        sec_base;
  hsv2rgb_pkg::sector_t sec_nxt;
  logic [RW-1:0]        rem_nxt;
  logic [CW-1:0]        sat_nxt;
  logic [CW-1:0]        val_nxt;

  always_comb begin
    hue_c = (in_hue >= HW'(hsv2rgb_pkg::HUE_FULL)) ? '0 : in_hue;
    if (hue_c >= HW'(5 * SEC)) begin
      sec_nxt  = hsv2rgb_pkg::SEC_5;
      sec_base = HW'(5 * SEC);
    end else if (hue_c >= HW'(4 * SEC)) begin
      sec_nxt  = hsv2rgb_pkg::SEC_4;
      sec_base = HW'(4 * SEC);
    end else if (hue_c >= HW'(3 * SEC)) begin
      sec_nxt  = hsv2rgb_pkg::SEC_3;
      sec_base = HW'(3 * SEC);
    end else if (hue_c >= HW'(2 * SEC)) begin
      sec_nxt  = hsv2rgb_pkg::SEC_2;
      sec_base = HW'(2 * SEC);
    end else if (hue_c >= HW'(SEC)) begin
      sec_nxt  = hsv2rgb_pkg::SEC_1;
      sec_base = HW'(SEC);
    end else begin
      sec_nxt  = hsv2rgb_pkg::SEC_0;
      sec_base = '0;
    end
    rem_nxt = RW'(hue_c - sec_base);
    sat_nxt = (in_sat > ONE) ? ONE : in_sat;
    val_nxt = (in_val > ONE) ? ONE : in_val;
  end

  hsv2rgb_pkg::sector_t s1_sec_r;
  logic [RW-1:0]        s1_rem_r;
  logic [CW-1:0]        s1_sat_r;
  logic [CW-1:0]        s1_val_r;

  always_ff @(posedge clk) begin
    if (s1_rdy && in_tvalid) begin
      s1_sec_r <= sec_nxt;
      s1_rem_r <= rem_nxt;
      s1_sat_r <= sat_nxt;
      s1_val_r <= val_nxt;
    end
  end

  // ---------------- Stage 2: fraction f = rem + rem/15, p = v(1-s)
  logic [hsv2rgb_pkg::RECIP_PW-1:0] recip_prod;
  logic [RW-1:0]                    f_nxt;
  logic [PW-1:0]                    p_prod;
  logic [CW-1:0]                    p_nxt;

  always_comb begin
    recip_prod = hsv2rgb_pkg::RECIP_PW'(s1_rem_r)
               * hsv2rgb_pkg::RECIP_PW'(hsv2rgb_pkg::RECIP_K);
    f_nxt  = s1_rem_r + RW'(recip_prod >> hsv2rgb_pkg::RECIP_SHIFT);
    p_prod = PW'(s1_val_r) * PW'(ONE - s1_sat_r);
    p_nxt  = p_prod[FB+CW-1:FB];
  end

  hsv2rgb_pkg::sector_t s2_sec_r;
  logic [RW-1:0]        s2_f_r;
  logic [CW-1:0]        s2_sat_r;
  logic [CW-1:0]        s2_val_r;
  logic [CW-1:0]        s2_p_r;

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      s2_sec_r <= s1_sec_r;
      s2_f_r   <= f_nxt;
      s2_sat_r <= s1_sat_r;
      s2_val_r <= s1_val_r;
      s2_p_r   <= p_nxt;
    end
  end

  // ---------------- Stage 3: factors 1 - s*f and 1 - s*(1-f)
  logic [PW-1:0] sf_prod;
  logic [PW-1:0] sg_prod;
  logic [CW-1:0] qa_nxt;
  logic [CW-1:0] tb_nxt;

  always_comb begin
    sf_prod = PW'(s2_sat_r) * PW'(s2_f_r);
    sg_prod = PW'(s2_sat_r) * PW'(ONE - CW'(s2_f_r));
    qa_nxt  = ONE - sf_prod[FB+CW-1:FB];
    tb_nxt  = ONE - sg_prod[FB+CW-1:FB];
  end

  hsv2rgb_pkg::sector_t s3_sec_r;
  logic [CW-1:0]        s3_qa_r;
  logic [CW-1:0]        s3_tb_r;
  logic [CW-1:0]        s3_val_r;
  logic [CW-1:0]        s3_p_r;

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_vld_r) begin
      s3_sec_r <= s2_sec_r;
      s3_qa_r  <= qa_nxt;
      s3_tb_r  <= tb_nxt;
      s3_val_r <= s2_val_r;
      s3_p_r   <= s2_p_r;
    end
  end

  // ---------------- Stage 4: q, t and channel order by sector
  logic [PW-1:0] q_prod;
  logic [PW-1:0] t_prod;
  logic [CW-1:0] q_val;
  logic [CW-1:0] t_val;
  logic [CW-1:0] red_nxt, green_nxt, blue_nxt;

  always_comb begin
    q_prod = PW'(s3_val_r) * PW'(s3_qa_r);
    t_prod = PW'(s3_val_r) * PW'(s3_tb_r);
    q_val  = q_prod[FB+CW-1:FB];
    t_val  = t_prod[FB+CW-1:FB];
    unique case (s3_sec_r)
      hsv2rgb_pkg::SEC_0: begin
        red_nxt = s3_val_r; green_nxt = t_val;    blue_nxt = s3_p_r;
      end
      hsv2rgb_pkg::SEC_1: begin
        red_nxt = q_val;    green_nxt = s3_val_r; blue_nxt = s3_p_r;
      end
      hsv2rgb_pkg::SEC_2: begin
        red_nxt = s3_p_r;   green_nxt = s3_val_r; blue_nxt = t_val;
      end
      hsv2rgb_pkg::SEC_3: begin
        red_nxt = s3_p_r;   green_nxt = q_val;    blue_nxt = s3_val_r;
      end
      hsv2rgb_pkg::SEC_4: begin
        red_nxt = t_val;    green_nxt = s3_p_r;   blue_nxt = s3_val_r;
      end
      default: begin
        red_nxt = s3_val_r; green_nxt = s3_p_r;   blue_nxt = q_val;
      end
    endcase
  end

  logic [CW-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_vld_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  // Output beat.
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(hsv2rgb_pkg::OUT_DATA_W - 3 * CW){1'b0}}, blue_r, green_r, red_r};

  // ---------------- Assertions
  `HSV2RGB_ASSERT_NOW(a_s1_range, s1_vld_r,
    (s1_rem_r < RW'(SEC)) && (s1_sat_r <= ONE) && (s1_val_r <= ONE),
    "stage 1 remainder or clipped inputs out of range")
  `HSV2RGB_ASSERT_NOW(a_s3_factor, s3_vld_r,
    (s3_qa_r != '0) && (s3_qa_r <= ONE) && (s3_tb_r <= ONE),
    "stage 3 factors out of range")
  `HSV2RGB_ASSERT_NOW(a_out_range, out_vld_r,
    (red_r <= ONE) && (green_r <= ONE) && (blue_r <= ONE),
    "output channel above one")
  `HSV2RGB_ASSERT_NEXT(a_out_fill, s3_vld_r && s4_rdy, out_vld_r,
    "pixel lost between stage 3 and output")

endmodule

`default_nettype wire
